>>> hw/rtl/ogbag_pkg.sv
// ----------------------------------------------------------------------------
// ogbag_pkg: shared types and constants for the osd glyph blit address generator
// cell map geometry, field widths, payload structs, register indexes and
// the command/status groups between the controller and the datapath
// ----------------------------------------------------------------------------
package ogbag_pkg;

    // cell map geometry
    localparam int COLS        = 53;
    localparam int ROWS        = 20;
    localparam int MAX_GLYPH_W = 36;
    localparam int CELLS       = COLS * ROWS;
    localparam int CELL_AW     = $clog2(CELLS);

    // field widths
    localparam int FB_W      = 13;
    localparam int GW_W      = 6;
    localparam int OFS_W     = 8;
    localparam int CODE_W    = 16;
    localparam int FBI_W     = 24;
    localparam int FPI_W     = 19;
    localparam int PROD_W    = 12;
    localparam int GAREA_W   = 20;
    localparam int COORD_W   = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DW    = 13;

    // item modes
    localparam logic [1:0] MODE_WRITE  = 2'd0;
    localparam logic [1:0] MODE_CLEAR  = 2'd1;
    localparam logic [1:0] MODE_RENDER = 2'd2;

    // rotation codes
    localparam logic [1:0] ROT_0   = 2'd0;
    localparam logic [1:0] ROT_90  = 2'd1;
    localparam logic [1:0] ROT_180 = 2'd2;
    localparam logic [1:0] ROT_270 = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FB_WIDTH     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FB_HEIGHT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROTATION     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GLYPH_WIDTH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GLYPH_HEIGHT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_PAGE_PRESENT = 3'd7;

    // input item
    typedef struct packed {
        logic [1:0]        mode;
        logic [5:0]        cell_x;
        logic [4:0]        cell_y;
        logic [CODE_W-1:0] char_code;
        logic [5:0]        glyph_row;
    } in_item_t;

    // result item
    typedef struct packed {
        logic [FBI_W-1:0] fb_pixel_index;
        logic [1:0]       font_page;
        logic [FPI_W-1:0] font_pixel_index;
        logic             last;
    } out_item_t;

    // configuration registers
    typedef struct packed {
        logic [FB_W-1:0]  fb_width;
        logic [FB_W-1:0]  fb_height;
        logic [1:0]       rotation_code;
        logic [GW_W-1:0]  glyph_width;
        logic [GW_W-1:0]  glyph_height;
        logic [OFS_W-1:0] offset_x;
        logic [OFS_W-1:0] offset_y;
        logic [3:0]       page_present;
    } cfg_t;

    // controller to datapath
    typedef struct packed {
        logic latch;
        logic wr_cell;
        logic clr_step;
        logic rd_cell;
        logic calc1;
        logic calc2;
        logic step;
        logic load_hold;
        logic push_out;
        logic push_last;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic in_range;
        logic row_ok;
        logic code_zero;
        logic cand_valid;
        logic gx_last;
        logic clr_last;
    } sts_t;

endpackage

>>> hw/rtl/osd_glyph_blit_address_generator.sv
// ----------------------------------------------------------------------------
// osd_glyph_blit_address_generator: character cell map and glyph row addressing
// keeps the osd cell map and, per render item, lists framebuffer and font
// pixel addresses for one glyph row under the selected rotation
// ----------------------------------------------------------------------------
// usage
// - item channel (item_valid / item_stall / item): one transfer per command;
//   write a cell, clear the map, or render one glyph row of one cell
// - pixel channel (pixel_valid / pixel_stall / pixel): one transfer per
//   on-screen pixel, last marks the final pixel of the row; write and clear
//   items produce no transfer
// - cfg channel (cfg_valid / cfg_ready / cfg_index / cfg_data): always ready;
//   write it only while the block is idle, which the block does not enforce
// - sequencing: a render passes through setup steps (accept, map read,
//   address setup, index setup), then walks the glyph columns and ends
//   with a flush step; the pixel loop steps one column per cycle through
//   a one-deep hold stage, unless a held pixel waits on a stalled output
// - a clear sweeps the 1060-entry map ram one entry per cycle
// - after reset the same clearing pass runs before the first item
//   is taken; configuration writes are taken throughout
// - while the receiver stalls the output register holds its pixel and the
//   column loop waits; a new item may be taken while a last pixel still waits
// ----------------------------------------------------------------------------
module osd_glyph_blit_address_generator import ogbag_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    // command items
    input  logic                 item_valid,
    output logic                 item_stall,
    input  in_item_t             item,
    // pixel results
    output logic                 pixel_valid,
    input  logic                 pixel_stall,
    output out_item_t            pixel,
    // register writes
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DW-1:0]    cfg_data
);

    cfg_t cfg_reg;
    cmd_t cmd;
    sts_t sts;

    assign cfg_ready = 1'b1;

    // register file, reset to the power-on display setup
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.fb_width      <= FB_W'(1280);
            cfg_reg.fb_height     <= FB_W'(720);
            cfg_reg.rotation_code <= ROT_0;
            cfg_reg.glyph_width   <= GW_W'(24);
            cfg_reg.glyph_height  <= GW_W'(36);
            cfg_reg.offset_x      <= OFS_W'(5);
            cfg_reg.offset_y      <= '0;
            cfg_reg.page_present  <= 4'd1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_FB_WIDTH:     cfg_reg.fb_width      <= cfg_data[FB_W-1:0];
                REG_FB_HEIGHT:    cfg_reg.fb_height     <= cfg_data[FB_W-1:0];
                REG_ROTATION:     cfg_reg.rotation_code <= cfg_data[1:0];
                REG_GLYPH_WIDTH:  cfg_reg.glyph_width   <= cfg_data[GW_W-1:0];
                REG_GLYPH_HEIGHT: cfg_reg.glyph_height  <= cfg_data[GW_W-1:0];
                REG_OFFSET_X:     cfg_reg.offset_x      <= cfg_data[OFS_W-1:0];
                REG_OFFSET_Y:     cfg_reg.offset_y      <= cfg_data[OFS_W-1:0];
                REG_PAGE_PRESENT: cfg_reg.page_present  <= cfg_data[3:0];
                default:          cfg_reg               <= cfg_reg;
            endcase
        end
    end

    // sequencing
    ogbag_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_mode   (item.mode),
        .item_stall  (item_stall),
        .pixel_valid (pixel_valid),
        .pixel_stall (pixel_stall),
        .sts         (sts),
        .cmd         (cmd)
    );

    // map storage and address arithmetic
    ogbag_dp u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_reg),
        .item  (item),
        .cmd   (cmd),
        .sts   (sts),
        .pixel (pixel)
    );

endmodule

>>> hw/rtl/ogbag_ram.sv
// ----------------------------------------------------------------------------
// ogbag_ram: generic single-port-write, single-port-read ram
// one write and one registered read per cycle, no reset on the array
// ----------------------------------------------------------------------------
module ogbag_ram #(
    parameter int  WIDTH = 16,
    parameter int  DEPTH = 1060,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> hw/rtl/ogbag_ctrl.sv
// ----------------------------------------------------------------------------
// ogbag_ctrl: sequencing state machine
// walks each item through write, clear sweep, render setup and pixel run,
// and owns the hold and output valid flags
// ----------------------------------------------------------------------------
module ogbag_ctrl import ogbag_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    input  logic [1:0] item_mode,
    output logic       item_stall,
    output logic       pixel_valid,
    input  logic       pixel_stall,
    input  sts_t       sts,
    output cmd_t       cmd
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_WRITE,
        S_READ,
        S_CALC1,
        S_CALC2,
        S_RUN,
        S_FLUSH
    } state_t;

    state_t state_reg, state_next;
    logic   hold_valid_reg, hold_valid_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free    = !out_valid_reg || !pixel_stall;
    assign item_stall  = (state_reg != S_IDLE);
    assign pixel_valid = out_valid_reg;

    always_comb
    begin
        cmd             = '0;
        state_next      = state_reg;
        hold_valid_next = hold_valid_reg;
        out_valid_next  = out_valid_reg && pixel_stall;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.latch = 1'b1;
                    case (item_mode)
                        MODE_WRITE:  state_next = S_WRITE;
                        MODE_CLEAR:  state_next = S_CLEAR;
                        MODE_RENDER: state_next = S_READ;
                        default:     state_next = S_IDLE;
                    endcase
                end
            end
            S_WRITE:
            begin
                cmd.wr_cell = sts.in_range;
                state_next  = S_IDLE;
            end
            S_READ:
            begin
                cmd.rd_cell = 1'b1;
                state_next  = (sts.in_range && sts.row_ok) ? S_CALC1 : S_IDLE;
            end
            S_CALC1:
            begin
                cmd.calc1  = 1'b1;
                state_next = sts.code_zero ? S_IDLE : S_CALC2;
            end
            S_CALC2:
            begin
                cmd.calc2  = 1'b1;
                state_next = S_RUN;
            end
            S_RUN:
            begin
                if (sts.cand_valid)
                begin
                    if (!hold_valid_reg)
                    begin
                        cmd.load_hold   = 1'b1;
                        cmd.step        = 1'b1;
                        hold_valid_next = 1'b1;
                    end
                    else if (out_free)
                    begin
                        // pending pixel is not the last one, pass it on
                        cmd.push_out   = 1'b1;
                        cmd.load_hold  = 1'b1;
                        cmd.step       = 1'b1;
                        out_valid_next = 1'b1;
                    end
                end
                else
                begin
                    cmd.step = 1'b1;
                end
                if (cmd.step && sts.gx_last)
                begin
                    state_next = S_FLUSH;
                end
            end
            S_FLUSH:
            begin
                if (!hold_valid_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (out_free)
                begin
                    cmd.push_out    = 1'b1;
                    cmd.push_last   = 1'b1;
                    out_valid_next  = 1'b1;
                    hold_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

endmodule

>>> hw/rtl/ogbag_dp.sv
// ----------------------------------------------------------------------------
// ogbag_dp: cell map and address datapath
// holds the cell map ram, the render setup products, the stepping pixel
// coordinates and indexes, the one-deep hold stage and the output register
// ----------------------------------------------------------------------------
module ogbag_dp import ogbag_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    input  in_item_t  item,
    input  cmd_t      cmd,
    output sts_t      sts,
    output out_item_t pixel
);

    in_item_t                   it_reg;
    logic [CELL_AW-1:0]         clr_cnt_reg, clr_cnt_next;
    logic [PROD_W-1:0]          cxgw_reg, cygh_reg, area_reg, rowgw_reg, osdw_reg, osdh_reg;
    logic [1:0]                 page_reg;
    logic [GAREA_W-1:0]         garea_reg;
    logic signed [COORD_W-1:0]  rx_reg, ry_reg;
    logic [FBI_W-1:0]           fbi_reg, hold_fbi_reg;
    logic [FPI_W-1:0]           fpi_reg, hold_fpi_reg;
    logic [GW_W-1:0]            gx_reg;
    out_item_t                  out_reg;

    logic [GW_W-1:0]            gw;
    logic [CELL_AW-1:0]         cell_addr;
    logic [CELL_AW-1:0]         ram_waddr;
    logic [CODE_W-1:0]          ram_wdata;
    logic [CODE_W-1:0]          ram_rdata;
    logic [1:0]                 page_sel;
    logic [1:0]                 page_next;
    logic signed [COORD_W-1:0]  rx0_next, ry0_next;
    logic signed [COORD_W-1:0]  rx_step, ry_step;
    logic [FBI_W-1:0]           fbi_step;
    logic signed [FB_W:0]       fw_s;
    logic signed [2*COORD_W-3:0] fb_prod;

    // effective glyph width, clamped
    assign gw = (32'(cfg.glyph_width) > 32'(MAX_GLYPH_W)) ? GW_W'(MAX_GLYPH_W)
                                                           : cfg.glyph_width;

    assign cell_addr = CELL_AW'(it_reg.cell_y) * CELL_AW'(COLS) + CELL_AW'(it_reg.cell_x);
    assign ram_waddr = cmd.clr_step ? clr_cnt_reg : cell_addr;
    assign ram_wdata = cmd.clr_step ? '0 : it_reg.char_code;

    ogbag_ram #(
        .WIDTH (CODE_W),
        .DEPTH (CELLS)
    ) u_map (
        .clk   (clk),
        .we    (cmd.wr_cell || cmd.clr_step),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.rd_cell),
        .raddr (cell_addr),
        .rdata (ram_rdata)
    );

    // page fallback to page 0 when not loaded
    assign page_sel  = ram_rdata[9:8];
    assign page_next = cfg.page_present[page_sel] ? page_sel : 2'd0;

    // start coordinates of glyph column 0 in the rotated framebuffer
    always_comb
    begin
        logic signed [COORD_W-1:0] xo, yo, cxgw, cygh, row, osdw, osdh, fh;
        xo   = COORD_W'($signed(cfg.offset_x));
        yo   = COORD_W'($signed(cfg.offset_y));
        cxgw = $signed(COORD_W'(cxgw_reg));
        cygh = $signed(COORD_W'(cygh_reg));
        row  = $signed(COORD_W'(it_reg.glyph_row));
        osdw = $signed(COORD_W'(osdw_reg));
        osdh = $signed(COORD_W'(osdh_reg));
        fh   = $signed(COORD_W'(cfg.fb_height));
        case (cfg.rotation_code)
            ROT_90:
            begin
                rx0_next = osdh + yo - 16'sd1 - cygh - row;
                ry0_next = cxgw + xo + xo;
            end
            ROT_180:
            begin
                rx0_next = osdw + xo - 16'sd1 - cxgw;
                ry0_next = osdh + yo - 16'sd1 - cygh - row;
            end
            ROT_270:
            begin
                rx0_next = cygh + row;
                ry0_next = fh - 16'sd1 - cxgw - xo;
            end
            default:
            begin
                rx0_next = cxgw + xo;
                ry0_next = cygh + yo + row;
            end
        endcase
    end

    // per-column steps
    always_comb
    begin
        case (cfg.rotation_code)
            ROT_90:
            begin
                rx_step  = 16'sd0;
                ry_step  = 16'sd1;
                fbi_step = FBI_W'(cfg.fb_width);
            end
            ROT_180:
            begin
                rx_step  = -16'sd1;
                ry_step  = 16'sd0;
                fbi_step = '1;
            end
            ROT_270:
            begin
                rx_step  = 16'sd0;
                ry_step  = -16'sd1;
                fbi_step = ~FBI_W'(cfg.fb_width) + FBI_W'(1);
            end
            default:
            begin
                rx_step  = 16'sd1;
                ry_step  = 16'sd0;
                fbi_step = FBI_W'(1);
            end
        endcase
    end

    assign fw_s    = $signed({1'b0, cfg.fb_width});
    assign fb_prod = ry_reg * fw_s;

    assign clr_cnt_next = (clr_cnt_reg == CELL_AW'(CELLS - 1)) ? '0 : clr_cnt_reg + 1'b1;

    assign sts.in_range   = (32'(it_reg.cell_x) < 32'(COLS)) && (32'(it_reg.cell_y) < 32'(ROWS));
    assign sts.row_ok     = cfg.page_present[0] && (it_reg.glyph_row < cfg.glyph_height)
                            && (gw != '0);
    assign sts.code_zero  = (ram_rdata == '0);
    assign sts.cand_valid = (rx_reg >= 0) && (ry_reg >= 0)
                            && (rx_reg < $signed(COORD_W'(cfg.fb_width)))
                            && (ry_reg < $signed(COORD_W'(cfg.fb_height)));
    assign sts.gx_last    = (gx_reg == gw - 1'b1);
    assign sts.clr_last   = (clr_cnt_reg == CELL_AW'(CELLS - 1));

    assign pixel = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (cmd.clr_step)
        begin
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            it_reg <= item;
        end
        if (cmd.rd_cell)
        begin
            cxgw_reg  <= PROD_W'(it_reg.cell_x) * PROD_W'(gw);
            cygh_reg  <= PROD_W'(it_reg.cell_y) * PROD_W'(cfg.glyph_height);
            area_reg  <= PROD_W'(cfg.glyph_height) * PROD_W'(gw);
            rowgw_reg <= PROD_W'(it_reg.glyph_row) * PROD_W'(gw);
            osdw_reg  <= PROD_W'(COLS) * PROD_W'(gw);
            osdh_reg  <= PROD_W'(ROWS) * PROD_W'(cfg.glyph_height);
        end
        if (cmd.calc1)
        begin
            page_reg  <= page_next;
            garea_reg <= GAREA_W'(ram_rdata[7:0]) * GAREA_W'(area_reg);
            rx_reg    <= rx0_next;
            ry_reg    <= ry0_next;
        end
        if (cmd.calc2)
        begin
            fbi_reg <= fb_prod[FBI_W-1:0] + FBI_W'(rx_reg);
            fpi_reg <= garea_reg[FPI_W-1:0] + FPI_W'(rowgw_reg);
            gx_reg  <= '0;
        end
        if (cmd.step)
        begin
            rx_reg  <= rx_reg + rx_step;
            ry_reg  <= ry_reg + ry_step;
            fbi_reg <= fbi_reg + fbi_step;
            fpi_reg <= fpi_reg + 1'b1;
            gx_reg  <= gx_reg + 1'b1;
        end
        if (cmd.push_out)
        begin
            out_reg.fb_pixel_index   <= hold_fbi_reg;
            out_reg.font_page        <= page_reg;
            out_reg.font_pixel_index <= hold_fpi_reg;
            out_reg.last             <= cmd.push_last;
        end
        if (cmd.load_hold)
        begin
            hold_fbi_reg <= fbi_reg;
            hold_fpi_reg <= fpi_reg;
        end
    end

endmodule

>>> dv/ogbag_pixel_checker.sv
// ----------------------------------------------------------------------------
// ogbag_pixel_checker: pixel address checker for the osd glyph blit block
// watches the item, pixel and register channels, keeps its own copy of the
// cell map and settings, works out the pixels each render should produce
// and compares every pixel transfer against the oldest one still due
// ----------------------------------------------------------------------------
module ogbag_pixel_checker import ogbag_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    input  logic                 item_stall,
    input  in_item_t             item,
    input  logic                 pixel_valid,
    input  logic                 pixel_stall,
    input  out_item_t            pixel,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DW-1:0]    cfg_data,
    output int                   error_count,
    output int                   pixels_pending
);

    cfg_t              settings;
    logic [CODE_W-1:0] cell_shadow [CELLS];
    out_item_t         pixels_due [$];
    int                mismatch_tally;

    // pixels one glyph row should land on screen, in column order
    task automatic predict_glyph_row(input logic [5:0] cx, input logic [4:0] cy,
                                     input logic [5:0] row);
        longint                  gw, gh, fw, fh, xo, yo, osd_w, osd_h;
        longint                  rx_min, ry_min, col_l, cy_l, row_l, glyph_l;
        longint                  gx, px, py, rx, ry;
        logic signed [OFS_W-1:0] ofs_x, ofs_y;
        logic [CODE_W-1:0]       code;
        logic [1:0]              page;
        logic [63:0]             wide;
        out_item_t               held;
        bit                      have_held;

        gw = (settings.glyph_width > MAX_GLYPH_W) ? MAX_GLYPH_W : settings.glyph_width;
        gh = settings.glyph_height;
        fw = settings.fb_width;
        fh = settings.fb_height;
        ofs_x = settings.offset_x;
        ofs_y = settings.offset_y;
        xo = ofs_x;
        yo = ofs_y;
        col_l = cx;
        cy_l = cy;
        row_l = row;
        osd_w = COLS * gw;
        osd_h = ROWS * gh;
        rx_min = 0;
        ry_min = 0;
        have_held = 1'b0;
        held = '0;

        if (cx >= COLS || cy >= ROWS || !settings.page_present[0])
            return;
        if (row_l >= gh || gw == 0)
            return;
        code = cell_shadow[cy * COLS + cx];
        if (code == '0)
            return;
        page = code[9:8];
        if (!settings.page_present[page])
            page = 2'd0;
        glyph_l = code[7:0];

        case (settings.rotation_code)
            ROT_90:
            begin
                rx_min = fh - (osd_h + 2 * yo);
                ry_min = -xo;
            end
            ROT_180:
            begin
                rx_min = fw - (osd_w + 2 * xo);
                ry_min = fh - (osd_h + 2 * yo);
            end
            ROT_270:
            begin
                // both offsets flip sign at 270
                xo = -xo;
                yo = -yo;
                rx_min = yo;
                ry_min = fw - (osd_w + 2 * xo) - (fh - osd_w);
            end
            default: ;
        endcase

        for (gx = 0; gx < gw; gx++)
        begin
            px = col_l * gw + xo + gx;
            py = cy_l * gh + yo + row_l;
            case (settings.rotation_code)
                ROT_90:
                begin
                    rx = fh - 1 - py - rx_min;
                    ry = px - ry_min;
                end
                ROT_180:
                begin
                    rx = fw - 1 - px - rx_min;
                    ry = fh - 1 - py - ry_min;
                end
                ROT_270:
                begin
                    rx = py - rx_min;
                    ry = fw - 1 - px - ry_min;
                end
                default:
                begin
                    rx = px;
                    ry = py;
                end
            endcase
            if (rx < 0 || ry < 0 || rx >= fw || ry >= fh)
                continue;
            // hold one back so the final one can carry last
            if (have_held)
                pixels_due.push_back(held);
            wide = ry * fw + rx;
            held.fb_pixel_index = wide[FBI_W-1:0];
            held.font_page = page;
            wide = glyph_l * (gh * gw) + row_l * gw + gx;
            held.font_pixel_index = wide[FPI_W-1:0];
            held.last = 1'b0;
            have_held = 1'b1;
        end
        if (have_held)
        begin
            held.last = 1'b1;
            pixels_due.push_back(held);
        end
    endtask

    task automatic compare_pixel(input out_item_t got);
        out_item_t want;

        if (pixels_due.size() == 0)
        begin
            $error("unexpected pixel transfer: fb_pixel_index %0d font_pixel_index %0d",
                   got.fb_pixel_index, got.font_pixel_index);
            mismatch_tally++;
            return;
        end
        want = pixels_due.pop_front();
        if (got.fb_pixel_index !== want.fb_pixel_index)
        begin
            $error("fb_pixel_index: expected %0d, got %0d",
                   want.fb_pixel_index, got.fb_pixel_index);
            mismatch_tally++;
        end
        if (got.font_page !== want.font_page)
        begin
            $error("font_page: expected %0d, got %0d", want.font_page, got.font_page);
            mismatch_tally++;
        end
        if (got.font_pixel_index !== want.font_pixel_index)
        begin
            $error("font_pixel_index: expected %0d, got %0d",
                   want.font_pixel_index, got.font_pixel_index);
            mismatch_tally++;
        end
        if (got.last !== want.last)
        begin
            $error("last: expected %0d, got %0d", want.last, got.last);
            mismatch_tally++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            settings = '{fb_width: 13'd1280, fb_height: 13'd720, rotation_code: ROT_0,
                         glyph_width: 6'd24, glyph_height: 6'd36, offset_x: 8'd5,
                         offset_y: 8'd0, page_present: 4'd1};
            foreach (cell_shadow[i])
                cell_shadow[i] = '0;
            pixels_due.delete();
            mismatch_tally = 0;
            error_count <= 0;
            pixels_pending <= 0;
        end
        else
        begin
            if (pixel_valid && !pixel_stall)
                compare_pixel(pixel);

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_FB_WIDTH:     settings.fb_width = cfg_data[FB_W-1:0];
                    REG_FB_HEIGHT:    settings.fb_height = cfg_data[FB_W-1:0];
                    REG_ROTATION:     settings.rotation_code = cfg_data[1:0];
                    REG_GLYPH_WIDTH:  settings.glyph_width = cfg_data[GW_W-1:0];
                    REG_GLYPH_HEIGHT: settings.glyph_height = cfg_data[GW_W-1:0];
                    REG_OFFSET_X:     settings.offset_x = cfg_data[OFS_W-1:0];
                    REG_OFFSET_Y:     settings.offset_y = cfg_data[OFS_W-1:0];
                    REG_PAGE_PRESENT: settings.page_present = cfg_data[3:0];
                    default: ;
                endcase
            end

            if (item_valid && !item_stall)
            begin
                case (item.mode)
                    MODE_WRITE:
                        if (item.cell_x < COLS && item.cell_y < ROWS)
                            cell_shadow[item.cell_y * COLS + item.cell_x] = item.char_code;
                    MODE_CLEAR:
                        foreach (cell_shadow[i])
                            cell_shadow[i] = '0;
                    MODE_RENDER:
                        predict_glyph_row(item.cell_x, item.cell_y, item.glyph_row);
                    default: ;
                endcase
            end

            error_count <= mismatch_tally;
            pixels_pending <= pixels_due.size();
        end
    end

endmodule

>>> dv/osd_glyph_blit_address_generator_tb.sv
// ----------------------------------------------------------------------------
// osd_glyph_blit_address_generator_tb: top of the osd glyph blit testbench
// drives command items and register writes into the block with random gaps
// and pixel-side stalls, leaves prediction and comparison to the pixel
// checker beside it, and turns its error count into the final verdict
// ----------------------------------------------------------------------------
module osd_glyph_blit_address_generator_tb;
    import ogbag_pkg::*;

    // mode 3 has no meaning in the block, still sent to check it stays quiet
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    localparam int MAX_IDLE     = 8;
    localparam int RESET_CYCLES = 12;
    // a clear sweeps 1060 map entries and produces no transfer, so give the
    // block that long to go idle before touching the registers
    localparam int SETTLE_CYCLES = 1100;
    // keep a wide margin over the slowest legal run
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int PHASES       = 13;

    logic                 clk         = 1'b0;
    logic                 rst_n       = 1'b0;
    logic                 item_valid  = 1'b0;
    logic                 item_stall;
    in_item_t             item        = '0;
    logic                 pixel_valid;
    logic                 pixel_stall = 1'b0;
    out_item_t            pixel;
    logic                 cfg_valid   = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index   = REG_FB_WIDTH;
    logic [CFG_DW-1:0]    cfg_data    = '0;

    int   error_count;
    int   pixels_pending;
    int   cycle_count = 0;

    // when set neither side idles, for back-to-back stretches
    bit   steady = 1'b0;
    // settings currently loaded, used only to aim glyph rows
    cfg_t active_cfg;
    // cells written lately as {cell_y, cell_x}, so renders hit filled cells
    logic [10:0] filled_cells [$];

    osd_glyph_blit_address_generator dut (.*);

    ogbag_pixel_checker pixel_check (.*);

    always #1 clk = ~clk;

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // pixel side: stall for a random count, then take one transfer
    initial
    begin : pixel_sink
        int hold;
        forever
        begin
            hold = steady ? 0 : $urandom_range(0, MAX_IDLE);
            if (hold != 0)
            begin
                pixel_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            pixel_stall <= 1'b0;
            do @(posedge clk); while (!(pixel_valid && !pixel_stall));
        end
    end

    // one register transfer; bits above the field are don't-care, so fill
    // them with noise
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DW-1:0] value,
                             input int width);
        logic [CFG_DW-1:0] noise;
        noise = CFG_DW'($urandom) << width;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= noise | value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic load_settings(input cfg_t c);
        write_reg(REG_FB_WIDTH, c.fb_width, FB_W);
        write_reg(REG_FB_HEIGHT, c.fb_height, FB_W);
        write_reg(REG_ROTATION, CFG_DW'(c.rotation_code), 2);
        write_reg(REG_GLYPH_WIDTH, CFG_DW'(c.glyph_width), GW_W);
        write_reg(REG_GLYPH_HEIGHT, CFG_DW'(c.glyph_height), GW_W);
        write_reg(REG_OFFSET_X, CFG_DW'(c.offset_x), OFS_W);
        write_reg(REG_OFFSET_Y, CFG_DW'(c.offset_y), OFS_W);
        write_reg(REG_PAGE_PRESENT, CFG_DW'(c.page_present), 4);
        active_cfg = c;
    endtask

    // one item transfer, then a random gap; with no gap valid stays high
    // so the next item follows back to back
    task automatic send_item(input in_item_t it);
        int gap;
        item_valid <= 1'b1;
        item <= it;
        do @(posedge clk); while (item_stall);
        gap = steady ? 0 : $urandom_range(0, MAX_IDLE);
        if (gap != 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // hold off the item side until every predicted pixel has come out
    task automatic wait_drained();
        item_valid <= 1'b0;
        @(posedge clk);
        while (pixels_pending != 0) @(posedge clk);
    endtask

    // drained and past the longest silent item, safe for register writes
    task automatic settle();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic in_item_t make_item(input logic [1:0] mode, input int cx, input int cy,
                                           input int code, input int row);
        in_item_t it;
        it.mode = mode;
        it.cell_x = 6'(cx);
        it.cell_y = 5'(cy);
        it.char_code = CODE_W'(code);
        it.glyph_row = 6'(row);
        return it;
    endfunction

    function automatic in_item_t random_item();
        in_item_t    it;
        int          roll;
        logic [10:0] pick;

        it = make_item(MODE_WRITE, $urandom_range(0, 63), $urandom_range(0, 31), $urandom,
                       $urandom_range(0, 63));
        roll = $urandom_range(0, 99);
        if (roll < 3)
            it.mode = MODE_CLEAR;
        else if (roll < 6)
            it.mode = MODE_UNUSED;
        else if (roll < 40)
        begin
            // mostly inside the map, sometimes anywhere the fields reach
            it.mode = MODE_WRITE;
            if ($urandom_range(0, 9) != 0)
            begin
                it.cell_x = 6'($urandom_range(0, COLS - 1));
                it.cell_y = 5'($urandom_range(0, ROWS - 1));
            end
            if ($urandom_range(0, 9) == 0)
                it.char_code = '0;
            if (it.cell_x < COLS && it.cell_y < ROWS)
            begin
                filled_cells.push_back({it.cell_y, it.cell_x});
                if (filled_cells.size() > 64)
                    void'(filled_cells.pop_front());
            end
        end
        else
        begin
            it.mode = MODE_RENDER;
            roll = $urandom_range(0, 99);
            if (roll < 75 && filled_cells.size() != 0)
            begin
                pick = filled_cells[$urandom_range(0, filled_cells.size() - 1)];
                {it.cell_y, it.cell_x} = pick;
            end
            else if (roll < 90)
            begin
                it.cell_x = 6'($urandom_range(0, COLS - 1));
                it.cell_y = 5'($urandom_range(0, ROWS - 1));
            end
            // rows inside the glyph most of the time
            if (active_cfg.glyph_height != 0 && $urandom_range(0, 99) < 85)
                it.glyph_row = 6'($urandom_range(0, active_cfg.glyph_height - 1));
        end
        return it;
    endfunction

    // settings for each phase: rotations, offset extremes, wrapping indexes,
    // zero sizes, missing pages, the smallest screen, then random ones
    function automatic cfg_t phase_settings(input int phase);
        cfg_t c;
        c = '{fb_width: 13'd1280, fb_height: 13'd720, rotation_code: ROT_0,
              glyph_width: 6'd24, glyph_height: 6'd36, offset_x: 8'd5,
              offset_y: 8'd0, page_present: 4'b0001};
        case (phase)
            0: c.rotation_code = ROT_90;
            1:
            begin
                c.rotation_code = ROT_180;
                c.offset_x = 8'h80;
                c.offset_y = 8'h7F;
                c.page_present = 4'b1111;
            end
            2:
            begin
                c.rotation_code = ROT_270;
                c.offset_x = 8'h7F;
                c.offset_y = 8'h80;
                c.glyph_width = 6'd12;
                c.glyph_height = 6'd18;
                c.page_present = 4'b0101;
            end
            3:
            begin
                // huge screen at 270 pushes both indexes past their widths,
                // width 63 is clipped to the widest glyph
                c.fb_width = 13'h1FFF;
                c.fb_height = 13'h1FFF;
                c.rotation_code = ROT_270;
                c.glyph_width = 6'd63;
                c.glyph_height = 6'd63;
                c.offset_x = 8'hFF;
                c.offset_y = 8'hFF;
                c.page_present = 4'b1111;
            end
            4:
            begin
                c.fb_width = '0;
                c.rotation_code = 2'($urandom);
            end
            5: c.glyph_width = '0;
            6:
            begin
                c.glyph_height = '0;
                c.fb_height = '0;
            end
            7: c.page_present = 4'b1110;
            8:
            begin
                c.fb_width = 13'd1;
                c.fb_height = 13'd1;
                c.glyph_width = 6'd1;
                c.glyph_height = 6'd1;
                c.offset_x = '0;
                c.page_present = 4'b1111;
            end
            default:
            begin
                c.fb_width = FB_W'($urandom_range(1, 4096));
                c.fb_height = FB_W'($urandom_range(1, 4096));
                c.rotation_code = 2'($urandom);
                c.glyph_width = GW_W'($urandom_range(1, 36));
                c.glyph_height = GW_W'($urandom_range(1, 54));
                c.offset_x = OFS_W'($urandom);
                c.offset_y = OFS_W'($urandom);
                c.page_present = 4'($urandom);
                c.page_present[0] = ($urandom_range(0, 3) != 0);
            end
        endcase
        return c;
    endfunction

    initial
    begin : stimulus
        int items_in_phase;

        active_cfg = phase_settings(PHASES);
        active_cfg.glyph_height = 6'd36;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // directed items on the settings left by reset
        send_item(make_item(MODE_RENDER, 0, 0, 16'h0000, 0));     // empty cell
        send_item(make_item(MODE_WRITE, 0, 0, 16'h0041, 0));
        send_item(make_item(MODE_WRITE, 52, 19, 16'hFFFF, 0));    // absent page falls back
        send_item(make_item(MODE_WRITE, 63, 31, 16'hABCD, 63));   // outside map, dropped
        send_item(make_item(MODE_WRITE, 53, 0, 16'h0001, 0));
        send_item(make_item(MODE_WRITE, 0, 20, 16'h0001, 0));
        send_item(make_item(MODE_RENDER, 0, 0, 16'h0000, 0));
        send_item(make_item(MODE_RENDER, 52, 19, 16'hFFFF, 35));  // bottom-right cell
        send_item(make_item(MODE_RENDER, 52, 19, 16'h0000, 36));  // row past the glyph
        send_item(make_item(MODE_RENDER, 63, 31, 16'hFFFF, 63));  // outside map
        send_item(make_item(MODE_RENDER, 53, 0, 16'h0000, 0));
        send_item(make_item(MODE_RENDER, 0, 20, 16'h0000, 0));
        send_item(make_item(MODE_WRITE, 1, 0, 16'h0300, 0));      // page 3, glyph 0
        send_item(make_item(MODE_RENDER, 1, 0, 16'h0000, 17));
        send_item(make_item(MODE_WRITE, 2, 0, 16'h0000, 0));      // code zero written
        send_item(make_item(MODE_RENDER, 2, 0, 16'h0000, 1));
        send_item(make_item(MODE_UNUSED, 63, 31, 16'hFFFF, 63));
        send_item(make_item(MODE_RENDER, 0, 0, 16'h0000, 0));
        send_item(make_item(MODE_CLEAR, 0, 0, 16'h0000, 0));
        send_item(make_item(MODE_RENDER, 0, 0, 16'h0000, 0));     // cleared
        send_item(make_item(MODE_RENDER, 52, 19, 16'h0000, 35));
        send_item(make_item(MODE_WRITE, 10, 5, 16'h02FF, 0));
        send_item(make_item(MODE_RENDER, 10, 5, 16'h0000, 0));
        settle();

        // random phases, each on its own settings
        for (int phase = 0; phase < PHASES; phase++)
        begin
            load_settings(phase_settings(phase));
            steady = (phase == 1);
            if (phase < 4)
                items_in_phase = 40;
            else if (phase < 8)
                items_in_phase = 12;
            else if (phase == 8)
                items_in_phase = 20;
            else
                items_in_phase = 30;
            for (int n = 0; n < items_in_phase; n++)
            begin
                send_item(random_item());
                // now and then let the pixel side catch up completely
                if ($urandom_range(0, 39) == 0)
                    wait_drained();
            end
            settle();
        end

        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
